// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_REMOVED   = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_OVERFLOW  = 2'd3;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] data_in;
		logic signed [15:0] priority_req;
	} req_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		logic [1:0]         status;
		logic [4:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] prio;
		logic signed [31:0] value;
	} key_t;

	// shift controls broadcast to every cell
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

	// a <= b in (priority, value) order
	function automatic logic key_le(key_t a, key_t b);
		logic r;
		if (a.prio != b.prio) begin
			r = (a.prio < b.prio);
		end else begin
			r = (a.value <= b.value);
		end
		return r;
	endfunction

endpackage

// ===== design/sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps

// Sorted priority queue built as a chain of compare-and-shift cells.
// The result strobe (done) rises in the cycle after the item is accepted.
// Throughput: one item per cycle; every cell compares and shifts in parallel.
// busy never rises and the receiver cannot stall.
// Reset (arst_n low, async) empties the queue; entry contents need no clearing.
module sorted_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          done_q;
	rsp_t          rsp_q;

	key_t          keys [DEPTH];
	logic          les  [DEPTH];
	key_t          new_key;
	cell_ctrl_t    ctrl;
	logic          accept;
	logic          full;
	logic          empty;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign new_key = '{prio: req.priority_req, value: req.data_in};

	assign ctrl = '{insert: accept && (req.cmd == CMD_INSERT) && !full,
	                remove: accept && (req.cmd == CMD_REMOVE) && !empty};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		key_t l_key;
		logic l_le;
		key_t r_key;

		if (i == 0) begin : g_first
			assign l_key = new_key;
			assign l_le  = 1'b1;
		end else begin : g_mid
			assign l_key = keys[i-1];
			assign l_le  = les[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_key = keys[i];
		end else begin : g_inner
			assign r_key = keys[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (CW'(i) < count_q),
			.new_key  (new_key),
			.left_key (l_key),
			.left_le  (l_le),
			.right_key(r_key),
			.key      (keys[i]),
			.le       (les[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctrl.insert) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.remove) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (req.cmd)
				CMD_INSERT: begin
					rsp_q.data_out <= '0;
					if (full) begin
						rsp_q.status    <= ST_OVERFLOW;
						rsp_q.occupancy <= 5'(count_q);
					end else begin
						rsp_q.status    <= ST_INSERTED;
						rsp_q.occupancy <= 5'(count_q + CW'(1));
					end
				end
				CMD_REMOVE: begin
					if (empty) begin
						rsp_q.data_out  <= '0;
						rsp_q.status    <= ST_UNDERFLOW;
						rsp_q.occupancy <= 5'(count_q);
					end else begin
						rsp_q.data_out  <= keys[0].value;
						rsp_q.status    <= ST_REMOVED;
						rsp_q.occupancy <= 5'(count_q - CW'(1));
					end
				end
				default: begin
					rsp_q.data_out  <= '0;
					rsp_q.status    <= ST_UNDERFLOW;
					rsp_q.occupancy <= 5'(count_q);
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occupied,
	input  key_t       new_key,
	input  key_t       left_key,
	input  logic       left_le,
	input  key_t       right_key,
	output key_t       key,
	output logic       le
);

	key_t key_q;

	assign key = key_q;
	// entry stays in place on insert when it sorts at or before the new key
	assign le  = occupied && key_le(key_q, new_key);

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!le) begin
				key_q <= left_le ? new_key : left_key;
			end
		end else if (ctrl.remove) begin
			key_q <= right_key;
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import spq_pkg::*;

	localparam int QDEPTH      = 16;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	key_t        held[$];     // predicted queue contents, head first
	rsp_t        rsp_due[$];  // predicted results not yet seen
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned gap_pct = 0;

	always #1 clk = ~clk;

	sorted_priority_queue_unit #(.DEPTH(QDEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// flip sign bits so an unsigned compare follows (priority, value) order
	function automatic logic [47:0] order_code(key_t k);
		return {k.prio, k.value} ^ 48'h8000_8000_0000;
	endfunction

	function automatic rsp_t queue_response(req_t r);
		rsp_t o;
		key_t k;
		int   pos;
		o = '0;
		if (r.cmd == CMD_INSERT) begin
			if (held.size() >= QDEPTH) begin
				o.status = ST_OVERFLOW;
			end else begin
				k.prio  = r.priority_req;
				k.value = r.data_in;
				pos = 0;
				// equal keys: new entry goes behind
				while (pos < held.size() && order_code(held[pos]) <= order_code(k))
					pos++;
				held.insert(pos, k);
				o.status = ST_INSERTED;
			end
		end else if (held.size() == 0) begin
			o.status = ST_UNDERFLOW;
		end else begin
			k          = held.pop_front();
			o.data_out = k.value;
			o.status   = ST_REMOVED;
		end
		o.occupancy = 5'(held.size());
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR t=%0t %s: got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (rsp_due.size() == 0) begin
				report_mismatch("unexpected result", rsp.data_out, '0);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.data_out !== want.data_out)
					report_mismatch("data_out", rsp.data_out, want.data_out);
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.occupancy !== want.occupancy)
					report_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
			end
		end
	end

	function automatic req_t make_req(logic c, logic [31:0] d, logic [15:0] p);
		req_t r;
		r.cmd          = c;
		r.data_in      = d;
		r.priority_req = p;
		return r;
	endfunction

	// called right after a rising edge; returns after acceptance and any idle gap
	task automatic send_item(req_t item);
		logic stalled;
		start <= 1'b1;
		req   <= item;
		do begin
			@(negedge clk);
			stalled = busy;
			@(posedge clk);
		end while (stalled);
		rsp_due.push_back(queue_response(item));
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = 32'($signed($urandom_range(6)) - 3);
			1: case ($urandom_range(3))
				0: v = 32'h7fff_ffff;
				1: v = 32'h8000_0000;
				2: v = 32'h0;
				default: v = 32'hffff_ffff;
			endcase
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_prio();
		logic [15:0] p;
		case ($urandom_range(3))
			0, 1: p = 16'($signed($urandom_range(4)) - 2);
			2: p = $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: p = 16'($urandom_range(65535));
		endcase
		return p;
	endfunction

	task automatic test_underflow();
		send_item(make_req(CMD_REMOVE, 32'h0, 16'h0));
		send_item(make_req(CMD_REMOVE, 32'hffff_ffff, 16'hffff));
	endtask

	task automatic test_extremes();
		send_item(make_req(CMD_INSERT, 32'h0, 16'h0));
		send_item(make_req(CMD_INSERT, 32'h7fff_ffff, 16'h7fff));
		send_item(make_req(CMD_INSERT, 32'h8000_0000, 16'h8000));
		send_item(make_req(CMD_INSERT, 32'hffff_ffff, 16'h0));
		send_item(make_req(CMD_INSERT, 32'h1, 16'h0));
		send_item(make_req(CMD_INSERT, 32'h0, 16'h0));
		send_item(make_req(CMD_INSERT, 32'h8000_0000, 16'h7fff));
		send_item(make_req(CMD_INSERT, 32'h7fff_ffff, 16'h8000));
		send_item(make_req(CMD_REMOVE, 32'h0, 16'h0));
		send_item(make_req(CMD_REMOVE, 32'h0, 16'h0));
	endtask

	task automatic test_overflow();
		while (held.size() < QDEPTH)
			send_item(make_req(CMD_INSERT, pick_value(), pick_prio()));
		send_item(make_req(CMD_INSERT, 32'h8000_0000, 16'h8000));
		send_item(make_req(CMD_INSERT, 32'h7fff_ffff, 16'h7fff));
		repeat (3) send_item(make_req(CMD_REMOVE, 32'h0, 16'h0));
	endtask

	// bursts with a varying insert mix so the queue swings between empty and full
	task automatic test_random(int n, int unsigned idle_pct);
		int unsigned insert_pct;
		int          burst;
		gap_pct = idle_pct;
		while (n > 0) begin
			case ($urandom_range(2))
				0: insert_pct = 85;
				1: insert_pct = 50;
				default: insert_pct = 15;
			endcase
			burst = $urandom_range(16, 40);
			repeat (burst) begin
				send_item(make_req(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
					pick_value(), pick_prio()));
				n--;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_underflow();
		test_extremes();
		test_overflow();
		wait_drained();
		test_random(400, 9);
		wait_drained();
		test_random(400, 50);
		wait_drained();
		test_random(400, 0);
		wait_drained();

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_unit.sv
tb/tb.sv
